### src/sscan_pkg.sv
// types and constants shared by the spi adc scan sequencer
// item structs for the command and result channels, command codes, frame layout
`timescale 1ns / 1ps

package sscan_pkg;

	localparam int FRAME_BITS = 16;
	localparam int CODE_W     = 12;
	localparam int MODE_BIT   = 12;
	localparam int CH_LSB     = 7;
	localparam int CH_BITS    = 4;
	localparam int CFG_W      = 5;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] ADC_NONE = 2'd3;

	localparam logic REG_SMALL = 1'b0;
	localparam logic REG_LARGE = 1'b1;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] adc_address;
		logic [3:0] read_channel;
		logic       miso_bit;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  adc_select;
		logic        chip_select_n;
		logic        mosi_bit;
		logic        clock_pulse;
		logic        busy_res;
		logic        sample_valid;
		logic [3:0]  sample_channel;
		logic [11:0] sample_code;
		logic [11:0] read_code;
		logic        address_error;
	} res_item_t;

endpackage

### src/sscan_store.sv
// code store: one synchronous memory entry per channel, valid bits cleared at reset
// unwritten entries read as zero; depends on nothing outside this file
`timescale 1ns / 1ps

module sscan_store #(
	parameter int CHANNEL_COUNT = 16,
	parameter int CODE_BITS     = 12,
	parameter int AW            = $clog2(CHANNEL_COUNT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [CODE_BITS-1:0] wr_code,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [CODE_BITS-1:0] rd_code
);

	logic [CODE_BITS-1:0] mem [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] vld_q;
	logic [CODE_BITS-1:0] rd_data_q;
	logic rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_code;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_code = rd_hit_q ? rd_data_q : '0;

endmodule

### src/spi_adc_scan_sequencer.sv
// spi adc scan sequencer: the result item of an accepted item is registered and
// appears in the next cycle; throughput one item per cycle; the code store read
// and the result register share a single stage, a stalled result holds off the next item
// reset: idle, select lines at 3, channel counts 4 and 16, store entries read as
// zero through per-entry valid bits (no clearing pass)
`timescale 1ns / 1ps

module spi_adc_scan_sequencer #(
	parameter int CHANNEL_COUNT = 16,
	parameter int CODE_BITS     = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [4:0]              cfg_data,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  sscan_pkg::cmd_item_t    cmd_item,
	output logic                    res_valid,
	input  logic                    res_stall,
	output sscan_pkg::res_item_t    res_item
);

	localparam int AW = $clog2(CHANNEL_COUNT);
	localparam logic [4:0] CH_MAX = 5'(CHANNEL_COUNT);
	localparam logic [11:0] CODE_MASK = 12'((1 << CODE_BITS) - 1);

	logic [4:0] small_q, large_q;
	logic       busy_q, gap_q;
	logic [1:0] sel_q;
	logic [4:0] frame_q, total_q;
	logic [3:0] bit_q;
	logic [15:0] shift_q;

	logic       busy_d, gap_d;
	logic [1:0] sel_d;
	logic [4:0] frame_d, total_d;
	logic [3:0] bit_d;
	logic [15:0] shift_d;

	logic acc;
	logic res_valid_q;
	sscan_pkg::res_item_t res_s2, res_d;
	logic rd_s2;
	logic wr_en, rd_en;
	logic [CODE_BITS-1:0] rd_code;

	logic [4:0] n_sel, n_clamp, frame_inc;
	logic [15:0] word, shift_in;
	logic last_frames;

	assign cmd_stall = res_valid_q & res_stall;
	assign acc       = cmd_valid & ~cmd_stall;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_q <= 5'd4;
			large_q <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sscan_pkg::REG_SMALL: small_q <= cfg_data;
				sscan_pkg::REG_LARGE: large_q <= cfg_data;
			endcase
		end
	end

	// channel count for the start, saturated to 1..CHANNEL_COUNT
	always_comb begin
		n_sel = (cmd_item.adc_address == 2'd0) ? small_q : large_q;
		if (n_sel == 5'd0) begin
			n_clamp = 5'd1;
		end else if (n_sel > CH_MAX) begin
			n_clamp = CH_MAX;
		end else begin
			n_clamp = n_sel;
		end
	end

	assign frame_inc   = frame_q + 5'd1;
	assign last_frames = ({1'b0, frame_q} + 6'd2) >= {1'b0, total_q};
	assign shift_in    = {shift_q[14:0], cmd_item.miso_bit};

	always_comb begin
		word = '0;
		if (!last_frames) begin
			word[sscan_pkg::MODE_BIT] = 1'b1;
			word[sscan_pkg::CH_LSB +: sscan_pkg::CH_BITS] = frame_q[3:0];
		end
	end

	always_comb begin
		busy_d  = busy_q;
		gap_d   = gap_q;
		sel_d   = sel_q;
		frame_d = frame_q;
		total_d = total_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		res_d   = '0;

		unique case (cmd_item.command)
			sscan_pkg::CMD_START: begin
				if (!busy_q) begin
					if (cmd_item.adc_address == sscan_pkg::ADC_NONE) begin
						res_d.address_error = 1'b1;
					end else begin
						sel_d   = cmd_item.adc_address;
						total_d = n_clamp + 5'd2;
						frame_d = '0;
						bit_d   = 4'(sscan_pkg::FRAME_BITS - 1);
						gap_d   = 1'b0;
						shift_d = '0;
						busy_d  = 1'b1;
					end
				end
				res_d.chip_select_n = busy_d ? gap_d : 1'b1;
			end
			sscan_pkg::CMD_READ: begin
				rd_en = {1'b0, cmd_item.read_channel} < CH_MAX;
				res_d.chip_select_n = busy_q ? gap_q : 1'b1;
			end
			sscan_pkg::CMD_TICK: begin
				res_d.chip_select_n = 1'b1;
				if (busy_q) begin
					if (gap_q) begin
						gap_d   = 1'b0;
						frame_d = frame_inc;
						if (frame_inc >= total_q) begin
							busy_d  = 1'b0;
							sel_d   = sscan_pkg::ADC_NONE;
							frame_d = '0;
						end
					end else begin
						res_d.chip_select_n = 1'b0;
						res_d.clock_pulse   = 1'b1;
						res_d.mosi_bit      = word[bit_q];
						if (frame_q >= 5'd2) begin
							shift_d = shift_in;
						end
						if (bit_q == 4'd0) begin
							if (frame_q >= 5'd2) begin
								res_d.sample_valid   = 1'b1;
								res_d.sample_channel = shift_in[15:12];
								res_d.sample_code    = shift_in[11:0] & CODE_MASK;
								wr_en = {1'b0, shift_in[15:12]} < CH_MAX;
							end
							shift_d = '0;
							bit_d   = 4'(sscan_pkg::FRAME_BITS - 1);
							gap_d   = 1'b1;
						end else begin
							bit_d = bit_q - 4'd1;
						end
					end
				end
			end
			default: begin
				res_d.chip_select_n = 1'b1;
			end
		endcase

		res_d.adc_select = sel_d;
		res_d.busy_res   = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			gap_q       <= 1'b0;
			sel_q       <= sscan_pkg::ADC_NONE;
			frame_q     <= '0;
			total_q     <= '0;
			bit_q       <= 4'(sscan_pkg::FRAME_BITS - 1);
			shift_q     <= '0;
			res_valid_q <= 1'b0;
			rd_s2       <= 1'b0;
		end else begin
			if (acc) begin
				busy_q      <= busy_d;
				gap_q       <= gap_d;
				sel_q       <= sel_d;
				frame_q     <= frame_d;
				total_q     <= total_d;
				bit_q       <= bit_d;
				shift_q     <= shift_d;
				res_valid_q <= 1'b1;
				rd_s2       <= rd_en;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s2 <= res_d;
		end
	end

	sscan_store #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.CODE_BITS    (CODE_BITS),
		.AW           (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (acc & wr_en),
		.wr_addr(shift_in[12 +: AW]),
		.wr_code(shift_in[CODE_BITS-1:0]),
		.rd_en  (acc & rd_en),
		.rd_addr(cmd_item.read_channel[AW-1:0]),
		.rd_code(rd_code)
	);

	always_comb begin
		res_item = res_s2;
		res_item.read_code = rd_s2 ? 12'(rd_code) : 12'd0;
	end

endmodule
